>>> rtl/cfd_pkg.sv
// Shared constants, types and state codes of the command frame deframer.
package cfd_pkg;

    localparam int BUFFER_DEPTH = 32;
    localparam int IDX_W        = $clog2(BUFFER_DEPTH);
    localparam int FILL_W       = IDX_W + 1;
    // Two frame banks: one fills while the other drains.
    localparam int ADDR_W       = IDX_W + 1;
    localparam int MEM_DEPTH    = 2 * BUFFER_DEPTH;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    localparam int BYTE_W       = 8;
    localparam int POS_W        = 5;
    localparam int CNT_W        = 16;
    localparam int CFG_IDX_W    = 1;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hC8;
    localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'hC9;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 1'b1;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic              err;
        logic              bank;
        logic [FILL_W-1:0] last_pos;
        logic [CNT_W-1:0]  seen;
        logic [CNT_W-1:0]  good;
    } t_desc;

    typedef struct packed {
        logic en;
        logic bank;
    } t_release;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_LOAD
    } t_bk_state;

endpackage

>>> rtl/cfd_front.sv
// Front end: config registers, frame tracking, running checksum and frame classification.
module cfd_front import cfd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 i_rx_valid,
    output logic                 o_rx_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output t_mem_wr              o_mem_wr,
    output logic                 o_push,
    output t_desc                o_desc,
    input  logic                 i_q_full,
    input  t_release             i_release
);

    logic [BYTE_W-1:0] r_header;
    logic [BYTE_W-1:0] r_tail;
    logic              r_in_frame;
    logic [FILL_W-1:0] r_fill;
    logic [BYTE_W-1:0] r_sum;
    logic [BYTE_W-1:0] r_prev;
    logic [BYTE_W-1:0] r_first;
    logic              r_bank;
    logic [1:0]        r_busy;
    logic [1:0]        n_busy;
    logic [CNT_W-1:0]  r_seen;
    logic [CNT_W-1:0]  r_good;

    logic              accept;
    logic [FILL_W-1:0] fill_eff;
    logic [FILL_W-1:0] idx_full;
    logic [IDX_W-1:0]  idx;
    logic              is_hdr;
    logic              is_tail;
    logic              store;
    logic              closing;
    logic              frame_ok;
    logic [CNT_W-1:0]  seen_nx;
    logic [CNT_W-1:0]  good_nx;

    assign o_cfg_ready = 1'b1;
    assign o_rx_stall  = i_q_full || r_busy[r_bank];
    assign accept      = i_rx_valid && !o_rx_stall;

    always_comb begin
        // a full buffer restarts at index 0 before the byte is handled
        fill_eff = (r_fill >= FILL_W'(BUFFER_DEPTH)) ? '0 : r_fill;
        is_hdr   = (i_rx_byte == r_header);
        is_tail  = (i_rx_byte == r_tail);
        store    = r_in_frame || is_hdr;
        idx_full = is_hdr ? '0 : fill_eff;
        idx      = idx_full[IDX_W-1:0];
        closing  = accept && store && is_tail;
        // r_sum holds bytes 0..n-2 and r_prev byte n-1 of the n stored so far
        frame_ok = (idx_full >= FILL_W'(3)) && (r_first == r_header) && (r_sum == r_prev);
        seen_nx  = r_seen + CNT_W'(1);
        good_nx  = r_good + CNT_W'(1);

        n_busy = r_busy;
        if (i_release.en) begin
            n_busy[i_release.bank] = 1'b0;
        end
        // lock the filled bank until the back end has played it out
        if (closing && frame_ok) begin
            n_busy[r_bank] = 1'b1;
        end
    end

    always_comb begin
        o_mem_wr.en   = accept && store;
        o_mem_wr.addr = {r_bank, idx};
        o_mem_wr.data = i_rx_byte;

        o_push          = closing;
        o_desc.err      = !frame_ok;
        o_desc.bank     = r_bank;
        o_desc.last_pos = idx_full - FILL_W'(2);
        o_desc.seen     = seen_nx;
        o_desc.good     = frame_ok ? good_nx : r_good;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header   <= HEADER_RESET;
            r_tail     <= TAIL_RESET;
            r_in_frame <= 1'b0;
            r_fill     <= '0;
            r_bank     <= 1'b0;
            r_busy     <= '0;
            r_seen     <= '0;
            r_good     <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_HEADER: r_header <= i_cfg_data;
                    REG_TAIL:   r_tail   <= i_cfg_data;
                    default: ;
                endcase
            end
            r_busy <= n_busy;
            if (accept) begin
                r_fill <= store ? (idx_full + FILL_W'(1)) : fill_eff;
                if (store) begin
                    r_in_frame <= !is_tail;
                end
                if (closing) begin
                    r_seen <= seen_nx;
                    if (frame_ok) begin
                        // hand the filled bank to the back end and switch
                        r_good <= good_nx;
                        r_bank <= !r_bank;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && store) begin
            r_prev <= i_rx_byte;
            if (idx == '0) begin
                r_first <= i_rx_byte;
                r_sum   <= '0;
            end else begin
                r_sum <= r_sum + r_prev;
            end
        end
    end

endmodule

>>> rtl/cfd_queue.sv
// Short descriptor queue between the front end and the back end.
module cfd_queue import cfd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_desc o_head
);

    t_desc              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_count;

    logic               do_push;
    logic               do_pop;
    logic [QPTR_W-1:0]  wptr_nx;
    logic [QPTR_W-1:0]  rptr_nx;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_entry[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        wptr_nx = (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
        rptr_nx = (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= wptr_nx;
            end
            if (do_pop) begin
                r_rptr <= rptr_nx;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wptr] <= i_desc;
        end
    end

endmodule

>>> rtl/cfd_back.sv
// Back end: frame byte memory and the sequencer that plays out result beats.
module cfd_back import cfd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mem_wr           i_mem_wr,
    input  logic              i_q_empty,
    input  t_desc             i_q_head,
    output logic              o_pop,
    output t_release          o_release,
    output logic              o_res_valid,
    input  logic              i_res_stall,
    output logic              o_status,
    output logic [BYTE_W-1:0] o_frame_byte,
    output logic [POS_W-1:0]  o_byte_position,
    output logic              o_last,
    output logic [CNT_W-1:0]  o_frames_seen,
    output logic [CNT_W-1:0]  o_frames_good
);

    logic [BYTE_W-1:0] r_mem [MEM_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    t_bk_state         r_state;
    t_bk_state         n_state;

    logic              r_cur_bank;
    logic [FILL_W-1:0] r_cur_last;
    logic [CNT_W-1:0]  r_cur_seen;
    logic [CNT_W-1:0]  r_cur_good;
    logic [FILL_W-1:0] r_pos;

    logic              r_ovalid;
    logic              r_status;
    logic [BYTE_W-1:0] r_byte;
    logic [POS_W-1:0]  r_position;
    logic              r_last;
    logic [CNT_W-1:0]  r_seen_o;
    logic [CNT_W-1:0]  r_good_o;

    logic              out_free;
    logic              at_last;
    logic              take;
    logic              load_err;
    logic              rd_en;
    logic              load_data;

    assign out_free = !r_ovalid || !i_res_stall;
    assign at_last  = (r_pos == r_cur_last);

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty && out_free && !i_q_head.err) begin
                    n_state = BK_READ;
                end
            end
            BK_READ: begin
                if (out_free) begin
                    n_state = BK_LOAD;
                end
            end
            BK_LOAD: begin
                n_state = at_last ? BK_IDLE : BK_READ;
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop          = 1'b0;
        rd_en          = 1'b0;
        load_data      = 1'b0;
        o_release.en   = 1'b0;
        o_release.bank = r_cur_bank;
        case (r_state)
            BK_IDLE: begin
                o_pop = !i_q_empty && out_free;
            end
            BK_READ: begin
                rd_en = out_free;
            end
            BK_LOAD: begin
                load_data    = 1'b1;
                o_release.en = at_last;
            end
            default: ;
        endcase
        load_err = o_pop && i_q_head.err;
        take     = o_pop && !i_q_head.err;
    end

    always_ff @(posedge i_clk) begin
        if (i_mem_wr.en) begin
            r_mem[i_mem_wr.addr] <= i_mem_wr.data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[{r_cur_bank, r_pos[IDX_W-1:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_err || load_data) begin
                r_ovalid <= 1'b1;
            end else if (!i_res_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cur_bank <= i_q_head.bank;
            r_cur_last <= i_q_head.last_pos;
            r_cur_seen <= i_q_head.seen;
            r_cur_good <= i_q_head.good;
            r_pos      <= FILL_W'(1);
        end else if (load_data && !at_last) begin
            r_pos <= r_pos + FILL_W'(1);
        end

        if (load_err) begin
            r_status   <= 1'b1;
            r_byte     <= '0;
            r_position <= '0;
            r_last     <= 1'b1;
            r_seen_o   <= i_q_head.seen;
            r_good_o   <= i_q_head.good;
        end else if (load_data) begin
            r_status   <= 1'b0;
            r_byte     <= r_rdata;
            r_position <= POS_W'(r_pos);
            r_last     <= at_last;
            r_seen_o   <= r_cur_seen;
            r_good_o   <= r_cur_good;
        end
    end

    assign o_res_valid     = r_ovalid;
    assign o_status        = r_status;
    assign o_frame_byte    = r_byte;
    assign o_byte_position = r_position;
    assign o_last          = r_last;
    assign o_frames_seen   = r_seen_o;
    assign o_frames_good   = r_good_o;

endmodule

>>> rtl/command_frame_deframer_sum_check.sv
// Command frame deframer with 8-bit additive checksum check: top level.
//
// Received bytes enter on the rx channel (i_rx_valid / o_rx_stall / i_rx_byte), one beat per
// byte. Results leave on the result channel (o_res_valid / i_res_stall) with status,
// frame_byte, byte_position, last and both frame counters. An accepted frame yields one beat
// per content byte (type, subtype, payload) with last on the final one; a rejected frame
// yields a single beat with status set. Header and tail byte values are written through the
// cfg channel (index 0 header, index 1 tail), which is always ready.
// Flow: the front end takes one rx beat per cycle while o_rx_stall is low. Each result beat of
// a good frame passes BK_READ (the frame memory's registered read) and then BK_LOAD; o_res_valid
// follows the queue, BK_READ and BK_LOAD, or the queue pop alone for a reject beat.
// The frame memory holds two banks: a good frame's bank stays locked until its last beat is
// loaded, and the descriptor queue holds two closed frames. o_rx_stall rises while the bank
// to be filled is locked or the queue is full.
// Reset clears frame state and counters and loads header 0xC8 and tail 0xC9; there is no
// memory clearing pass. A stalled result beat holds on the outputs until taken.
module command_frame_deframer_sum_check import cfd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 i_rx_valid,
    output logic                 o_rx_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_res_valid,
    input  logic                 i_res_stall,
    output logic                 o_status,
    output logic [BYTE_W-1:0]    o_frame_byte,
    output logic [POS_W-1:0]     o_byte_position,
    output logic                 o_last,
    output logic [CNT_W-1:0]     o_frames_seen,
    output logic [CNT_W-1:0]     o_frames_good
);

    t_mem_wr  mem_wr;
    t_desc    push_desc;
    t_desc    head_desc;
    t_release release_bank;
    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_empty;

    cfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx_valid  (i_rx_valid),
        .o_rx_stall  (o_rx_stall),
        .i_rx_byte   (i_rx_byte),
        .o_mem_wr    (mem_wr),
        .o_push      (push),
        .o_desc      (push_desc),
        .i_q_full    (q_full),
        .i_release   (release_bank)
    );

    cfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head_desc)
    );

    cfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mem_wr        (mem_wr),
        .i_q_empty       (q_empty),
        .i_q_head        (head_desc),
        .o_pop           (pop),
        .o_release       (release_bank),
        .o_res_valid     (o_res_valid),
        .i_res_stall     (i_res_stall),
        .o_status        (o_status),
        .o_frame_byte    (o_frame_byte),
        .o_byte_position (o_byte_position),
        .o_last          (o_last),
        .o_frames_seen   (o_frames_seen),
        .o_frames_good   (o_frames_good)
    );

endmodule
